FILE: hdl/lfs_pkg.sv
package lfs_pkg;

  localparam int unsigned CENTER_POSITION = 2500;
  localparam int unsigned SPEED_LIMIT     = 400;
  localparam int unsigned ARM_WAIT        = 50;
  localparam int unsigned STEER_SHIFT     = 2;

  localparam int unsigned POS_W   = 13;
  localparam int unsigned LEVEL_W = 10;
  localparam int unsigned SPEED_W = 10;
  localparam int unsigned WAIT_W  = 10;
  localparam int unsigned CALC_W  = 12;
  localparam int unsigned DEV_W   = 14;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned PADDR_W     = 5;

  typedef enum logic [2:0] {
    REG_CRUISE_SPEED   = 3'd0,
    REG_HUNT_SPEED     = 3'd1,
    REG_LOST_THRESHOLD = 3'd2,
    REG_EDGE_THRESHOLD = 3'd3,
    REG_DEAD_BAND      = 3'd4,
    REG_CONTINUE_TIME  = 3'd5,
    REG_BACK_TIME      = 3'd6,
    REG_TURN_TIME      = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_TRACK   = 3'd0,
    PH_FORWARD = 3'd1,
    PH_BACK    = 3'd2,
    PH_PICK    = 3'd3,
    PH_SPIN    = 3'd4
  } phase_e;

  typedef struct packed {
    logic [8:0]  cruise_speed;
    logic [8:0]  hunt_speed;
    logic [12:0] lost_threshold;
    logic [9:0]  edge_threshold;
    logic [11:0] dead_band;
    logic [9:0]  continue_time;
    logic [9:0]  back_time;
    logic [9:0]  turn_time;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]   line_position;
    logic [LEVEL_W-1:0] left_edge_level;
    logic [LEVEL_W-1:0] right_edge_level;
    logic               random_bit;
  } reading_t;

  typedef struct packed {
    phase_e                    phase;
    logic                      turn_left_armed;
    logic                      turn_right_armed;
    logic                      spin_side;
    logic signed [SPEED_W-1:0] held_left_speed;
    logic signed [SPEED_W-1:0] held_right_speed;
  } steer_state_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic [WAIT_W-1:0]         wait_time;
  } drive_t;

  function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [CALC_W-1:0] v);
    logic signed [CALC_W-1:0] lim;
    lim = CALC_W'(SPEED_LIMIT);
    if (v > lim) begin
      return SPEED_W'(lim);
    end else if (v < -lim) begin
      return SPEED_W'(-lim);
    end
    return SPEED_W'(v);
  endfunction

endpackage

FILE: hdl/lfs_step.sv
module lfs_step import lfs_pkg::*; (
  input  cfg_t         cfg_i,
  input  steer_state_t state_i,
  input  reading_t     reading_i,
  output steer_state_t state_o,
  output drive_t       drive_o
);

  logic signed [CALC_W-1:0] ss_pos;
  logic signed [CALC_W-1:0] ss_neg;
  logic signed [CALC_W-1:0] ms_s;
  logic signed [DEV_W-1:0]  dev;
  logic signed [DEV_W-1:0]  ndev;
  logic signed [DEV_W-1:0]  db_s;
  logic [CALC_W-2:0]        quot;
  logic signed [CALC_W-1:0] l_raw;
  logic signed [CALC_W-1:0] r_raw;
  logic                     set_spd;
  logic                     lost;

  assign ss_pos = $signed({3'b000, cfg_i.hunt_speed});
  assign ss_neg = -ss_pos;
  assign ms_s   = $signed({3'b000, cfg_i.cruise_speed});
  assign dev    = $signed(DEV_W'(CENTER_POSITION)) - $signed({1'b0, reading_i.line_position});
  assign ndev   = -dev;
  assign db_s   = $signed({2'b00, cfg_i.dead_band});
  assign lost   = reading_i.line_position > cfg_i.lost_threshold;

  always_comb begin
    state_o           = state_i;
    drive_o.wait_time = '0;
    l_raw             = ms_s;
    r_raw             = ms_s;
    set_spd           = 1'b0;
    quot              = '0;
    if (state_i.turn_left_armed) begin
      state_o.turn_left_armed  = 1'b0;
      state_o.turn_right_armed = 1'b0;
      l_raw = ss_neg;
      r_raw = ss_pos;
      set_spd = 1'b1;
      drive_o.wait_time = cfg_i.turn_time;
    end else if (state_i.turn_right_armed) begin
      state_o.turn_left_armed  = 1'b0;
      state_o.turn_right_armed = 1'b0;
      l_raw = ss_pos;
      r_raw = ss_neg;
      set_spd = 1'b1;
      drive_o.wait_time = cfg_i.turn_time;
    end else if (lost) begin
      unique case (state_i.phase)
        PH_TRACK: begin
          state_o.phase = PH_FORWARD;
          l_raw = ss_pos;
          r_raw = ss_pos;
          set_spd = 1'b1;
          drive_o.wait_time = cfg_i.continue_time;
        end
        PH_FORWARD: begin
          state_o.phase = PH_BACK;
          l_raw = ss_neg;
          r_raw = ss_neg;
          set_spd = 1'b1;
          drive_o.wait_time = cfg_i.back_time;
        end
        PH_BACK: begin
          state_o.phase     = PH_PICK;
          state_o.spin_side = reading_i.random_bit;
        end
        PH_PICK: begin
          state_o.phase = PH_SPIN;
          l_raw = state_i.spin_side ? ss_pos : ss_neg;
          r_raw = state_i.spin_side ? ss_neg : ss_pos;
          set_spd = 1'b1;
        end
        PH_SPIN: begin
          state_o.phase = PH_SPIN;
        end
        default: begin
          state_o.phase = PH_TRACK;
        end
      endcase
    end else if (reading_i.left_edge_level > cfg_i.edge_threshold) begin
      state_o.turn_left_armed  = 1'b1;
      state_o.turn_right_armed = 1'b0;
      drive_o.wait_time = WAIT_W'(ARM_WAIT);
    end else if (reading_i.right_edge_level > cfg_i.edge_threshold) begin
      state_o.turn_right_armed = 1'b1;
      state_o.turn_left_armed  = 1'b0;
      drive_o.wait_time = WAIT_W'(ARM_WAIT);
    end else begin
      state_o.phase = PH_TRACK;
      set_spd = 1'b1;
      if (dev > db_s) begin
        quot  = (CALC_W-1)'(dev >>> STEER_SHIFT);
        l_raw = ms_s - $signed({1'b0, quot});
      end else if (dev < -db_s) begin
        quot  = (CALC_W-1)'(ndev >>> STEER_SHIFT);
        r_raw = ms_s - $signed({1'b0, quot});
      end
    end
    if (set_spd) begin
      state_o.held_left_speed  = sat_speed(l_raw);
      state_o.held_right_speed = sat_speed(r_raw);
    end
    drive_o.left_speed  = state_o.held_left_speed;
    drive_o.right_speed = state_o.held_right_speed;
  end

endmodule

FILE: hdl/line_follow_steering.sv
// An accepted reading is held in the input register, its result in the result
// register on the master side. Throughput: one reading per cycle while the master
// side takes results; the step between them is one pass of compare, subtract and
// saturate logic. Reset: asynchronous, active low; config and state registers go
// to defaults: search state tracking, no turn armed, both held speeds 200.
module line_follow_steering import lfs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // line_position[12:0], left_edge_level[22:13], right_edge_level[32:23],
  // random_bit[33], zero fill[39:34]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // left_speed[9:0], right_speed[19:10], wait_time[29:20], zero fill[31:30]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t         cfg_q;
  steer_state_t st_q;
  steer_state_t st_d;
  reading_t     rd_q;
  reading_t     rd_in;
  drive_t       drv_d;
  drive_t       drv_q;
  logic         s1_valid_q;
  logic         m_valid_q;
  logic         adv;
  logic         proc;
  logic         cfg_we;
  reg_idx_e     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_speed   <= 9'd400;
      cfg_q.hunt_speed     <= 9'd150;
      cfg_q.lost_threshold <= 13'd4985;
      cfg_q.edge_threshold <= 10'd990;
      cfg_q.dead_band      <= 12'd10;
      cfg_q.continue_time  <= 10'd150;
      cfg_q.back_time      <= 10'd160;
      cfg_q.turn_time      <= 10'd75;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CRUISE_SPEED:   cfg_q.cruise_speed   <= pwdata[8:0];
        REG_HUNT_SPEED:     cfg_q.hunt_speed     <= pwdata[8:0];
        REG_LOST_THRESHOLD: cfg_q.lost_threshold <= pwdata[12:0];
        REG_EDGE_THRESHOLD: cfg_q.edge_threshold <= pwdata[9:0];
        REG_DEAD_BAND:      cfg_q.dead_band      <= pwdata[11:0];
        REG_CONTINUE_TIME:  cfg_q.continue_time  <= pwdata[9:0];
        REG_BACK_TIME:      cfg_q.back_time      <= pwdata[9:0];
        REG_TURN_TIME:      cfg_q.turn_time      <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CRUISE_SPEED:   prdata = 32'(cfg_q.cruise_speed);
      REG_HUNT_SPEED:     prdata = 32'(cfg_q.hunt_speed);
      REG_LOST_THRESHOLD: prdata = 32'(cfg_q.lost_threshold);
      REG_EDGE_THRESHOLD: prdata = 32'(cfg_q.edge_threshold);
      REG_DEAD_BAND:      prdata = 32'(cfg_q.dead_band);
      REG_CONTINUE_TIME:  prdata = 32'(cfg_q.continue_time);
      REG_BACK_TIME:      prdata = 32'(cfg_q.back_time);
      REG_TURN_TIME:      prdata = 32'(cfg_q.turn_time);
      default:            prdata = '0;
    endcase
  end

  // advance the pipe whenever the result register is free or being taken
  assign adv           = !m_valid_q || m_axis_tready;
  assign proc          = adv && s1_valid_q;
  assign s_axis_tready = adv || !s1_valid_q;

  assign rd_in.line_position    = s_axis_tdata[12:0];
  assign rd_in.left_edge_level  = s_axis_tdata[22:13];
  assign rd_in.right_edge_level = s_axis_tdata[32:23];
  assign rd_in.random_bit       = s_axis_tdata[33];

  lfs_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (st_q),
    .reading_i (rd_q),
    .state_o   (st_d),
    .drive_o   (drv_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      st_q.phase            <= PH_TRACK;
      st_q.turn_left_armed  <= 1'b0;
      st_q.turn_right_armed <= 1'b0;
      st_q.spin_side        <= 1'b0;
      st_q.held_left_speed  <= 10'sd200;
      st_q.held_right_speed <= 10'sd200;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        m_valid_q <= s1_valid_q;
      end
      if (proc) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      rd_q <= rd_in;
    end
    if (proc) begin
      drv_q <= drv_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, drv_q.wait_time, drv_q.right_speed, drv_q.left_speed};

  a_one_turn_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.turn_left_armed && st_q.turn_right_armed))
    else $error("both turns armed");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.held_left_speed <= 10'sd400 && st_q.held_left_speed >= -10'sd400 &&
    st_q.held_right_speed <= 10'sd400 && st_q.held_right_speed >= -10'sd400)
    else $error("held speed outside saturation range");

  a_turn_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (st_q.turn_left_armed || st_q.turn_right_armed)
    |=> !st_q.turn_left_armed && !st_q.turn_right_armed)
    else $error("armed turn not cleared after request");

endmodule
